FILE: src/cvf_pkg.sv
// ============================================================================
// cvf_pkg
// Shared types and constants for the coincidence veto filter.
// ============================================================================
package cvf_pkg;

    localparam int VETO_DEPTH_DEF = 4096;

    localparam int KIND_W  = 2;
    localparam int PULSE_W = 24;
    localparam int STAMP_W = 32;
    localparam int WIN_W   = 16;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd80;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic start;
        logic advance;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic decided;
        logic out_free;
    } t_status;

endpackage

FILE: src/cvf_ram.sv
// ============================================================================
// cvf_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cvf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/cvf_ctrl.sv
// ============================================================================
// cvf_ctrl
// Controller: accepts items, steps the read pointer, releases results.
// ============================================================================
module cvf_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [cvf_pkg::KIND_W-1:0]  i_kind,
    output logic                        o_in_stall,
    input  cvf_pkg::t_status            i_status,
    output cvf_pkg::t_cmd               o_cmd
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_CHECK = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        cvf_pkg::KIND_LOAD:  o_cmd.load  = 1'b1;
                        cvf_pkg::KIND_CLEAR: o_cmd.clear = 1'b1;
                        cvf_pkg::KIND_EVENT: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                // A decided event waits here until the output register frees up.
                if (!i_status.decided) begin
                    o_cmd.advance = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/cvf_dpath.sv
// ============================================================================
// cvf_dpath
// Datapath: veto store, fill count, read pointer, window compare, output.
// ============================================================================
module cvf_dpath #(
    parameter int VETO_DEPTH = cvf_pkg::VETO_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cvf_pkg::t_cmd                i_cmd,
    output cvf_pkg::t_status             o_status,
    input  logic                         i_cfg_we,
    input  logic [cvf_pkg::WIN_W-1:0]    i_cfg_data,
    input  logic [cvf_pkg::PULSE_W-1:0]  i_pulse_number,
    input  logic [cvf_pkg::STAMP_W-1:0]  i_stamp,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_vetoed,
    output logic [cvf_pkg::PULSE_W-1:0]  o_passed_pulse,
    output logic [cvf_pkg::STAMP_W-1:0]  o_passed_stamp,
    output logic                         o_store_exhausted
);

    localparam int AW = $clog2(VETO_DEPTH);
    localparam int CW = $clog2(VETO_DEPTH + 1);
    localparam int SW = cvf_pkg::STAMP_W + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(VETO_DEPTH);

    logic [cvf_pkg::WIN_W-1:0]   r_window;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_idx;
    logic [CW-1:0]               n_idx;
    logic                        r_exh;
    logic [cvf_pkg::PULSE_W-1:0] r_pulse;
    logic [cvf_pkg::STAMP_W-1:0] r_stamp;
    logic                        r_in_pulse;

    logic                        r_out_valid;
    logic                        r_vetoed;
    logic [cvf_pkg::PULSE_W-1:0] r_out_pulse;
    logic [cvf_pkg::STAMP_W-1:0] r_out_stamp;
    logic                        r_out_exh;

    logic [cvf_pkg::PULSE_W-1:0] veto_pulse;
    logic [cvf_pkg::STAMP_W-1:0] veto_stamp;
    logic                        store_we;
    logic [SW-1:0]               vs_plus_w;
    logic [SW-1:0]               t_plus_w;
    logic [SW-1:0]               vs_ext;
    logic [SW-1:0]               t_ext;
    logic                        ran_out;
    logic                        same_pulse;
    logic                        skip;
    logic                        hit;

    assign store_we = i_cmd.load && (r_count < DEPTH_C);

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.clear) begin
            n_idx = '0;
        end else if (i_cmd.advance) begin
            n_idx = r_idx + CW'(1);
        end
    end

    // The read address follows the next pointer so the read data always
    // belongs to the pointer currently held in r_idx.
    cvf_ram #(
        .WIDTH(cvf_pkg::PULSE_W),
        .DEPTH(VETO_DEPTH)
    ) u_pulse_ram (
        .i_clk  (i_clk),
        .i_we   (store_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_pulse_number),
        .i_raddr(n_idx[AW-1:0]),
        .o_rdata(veto_pulse)
    );

    cvf_ram #(
        .WIDTH(cvf_pkg::STAMP_W),
        .DEPTH(VETO_DEPTH)
    ) u_stamp_ram (
        .i_clk  (i_clk),
        .i_we   (store_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_stamp),
        .i_raddr(n_idx[AW-1:0]),
        .o_rdata(veto_stamp)
    );

    assign vs_ext     = {1'b0, veto_stamp};
    assign t_ext      = {1'b0, r_stamp};
    assign vs_plus_w  = vs_ext + SW'(r_window);
    assign t_plus_w   = t_ext + SW'(r_window);
    assign ran_out    = r_exh || (r_idx >= r_count);
    assign same_pulse = (veto_pulse == r_pulse);
    // Once the pointer has stepped past a stale hit of the event's own pulse,
    // a hit of an earlier pulse ends the search instead of being skipped.
    assign skip       = !ran_out &&
                        ((!r_in_pulse && (veto_pulse < r_pulse)) ||
                         (same_pulse && (vs_plus_w < t_ext)));
    assign hit        = !ran_out && same_pulse &&
                        (vs_plus_w > t_ext) && (vs_ext < t_plus_w);

    assign o_status.decided  = !skip;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= cvf_pkg::WINDOW_RESET;
            r_count     <= '0;
            r_idx       <= '0;
            r_exh       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            r_idx <= n_idx;
            if (i_cmd.clear) begin
                r_count <= '0;
                r_exh   <= 1'b0;
            end else begin
                if (store_we) begin
                    r_count <= r_count + CW'(1);
                end
                if (i_cmd.finish && ran_out) begin
                    r_exh <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pulse    <= i_pulse_number;
            r_stamp    <= i_stamp;
            r_in_pulse <= 1'b0;
        end else if (i_cmd.advance && same_pulse) begin
            r_in_pulse <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_vetoed    <= hit;
            r_out_pulse <= r_pulse;
            r_out_stamp <= r_stamp;
            r_out_exh   <= ran_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_vetoed          = r_vetoed;
    assign o_passed_pulse    = r_out_pulse;
    assign o_passed_stamp    = r_out_stamp;
    assign o_store_exhausted = r_out_exh;

endmodule

FILE: src/coincidence_veto_filter_top.sv
// ============================================================================
// coincidence_veto_filter_top
// Flags detector events that fall inside the window of a stored veto hit.
// ============================================================================
//  Channel  Handshake                  Payload
//  in       i_in_valid / o_in_stall    i_kind, i_pulse_number, i_stamp
//  out      o_out_valid / i_out_stall  o_vetoed, o_passed_pulse, o_passed_stamp,
//                                      o_store_exhausted
//  cfg      i_cfg_valid / o_cfg_ready  i_cfg_data (window)
//
//  Load, clear and unused items are taken without stalling the input.
//  An event stalls the input while the read pointer steps past the veto hits it skips;
//  each step is one veto RAM read.
//  Reset is synchronous; the veto store needs no clearing pass.
//  One result may wait in the output register while the next item is taken;
//  an event that finds that register still full holds until it is taken.
module coincidence_veto_filter_top #(
    parameter int VETO_DEPTH = cvf_pkg::VETO_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [cvf_pkg::KIND_W-1:0]   i_kind,
    input  logic [cvf_pkg::PULSE_W-1:0]  i_pulse_number,
    input  logic [cvf_pkg::STAMP_W-1:0]  i_stamp,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_vetoed,
    output logic [cvf_pkg::PULSE_W-1:0]  o_passed_pulse,
    output logic [cvf_pkg::STAMP_W-1:0]  o_passed_stamp,
    output logic                         o_store_exhausted,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cvf_pkg::WIN_W-1:0]    i_cfg_data
);

    cvf_pkg::t_cmd    w_cmd;
    cvf_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    cvf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_kind    (i_kind),
        .o_in_stall(o_in_stall),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    cvf_dpath #(
        .VETO_DEPTH(VETO_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_pulse_number   (i_pulse_number),
        .i_stamp          (i_stamp),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_vetoed         (o_vetoed),
        .o_passed_pulse   (o_passed_pulse),
        .o_passed_stamp   (o_passed_stamp),
        .o_store_exhausted(o_store_exhausted)
    );

`ifndef NO_ASSERTIONS
    // An event classified against an exhausted store is never vetoed.
    a_exhausted_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_store_exhausted) |-> !o_vetoed)
        else $error("exhausted store produced a vetoed event");

    // A new result only appears after the controller finished an event.
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.finish))
        else $error("result appeared without a finished event");

    // An accepted event keeps the input stalled on the next cycle.
    a_event_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_kind == cvf_pkg::KIND_EVENT)) |=> o_in_stall)
        else $error("input not stalled while an event is classified");

    // Finish is never issued together with an advance or onto a full output register.
    a_no_advance_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> !w_cmd.advance && w_status.out_free)
        else $error("finish issued together with advance or onto a full output");
`endif

endmodule
